### rtl/affinv_pkg.sv
// ----------------------------------------------------------------------------
// affinv_pkg
// Shared types and constants for the 3x4 affine transform inverse.
// ----------------------------------------------------------------------------
package affinv_pkg;

    // result rows per matrix and the row index field
    localparam int ROW_W  = 2;
    localparam int N_ROWS = 3;
    localparam int N_COLS = 4;

    localparam logic [ROW_W-1:0] FIRST_ROW = 2'd0;
    localparam logic [ROW_W-1:0] LAST_ROW  = 2'd2;

    // result tuser bit positions
    localparam int USER_W        = 2;
    localparam int USER_SINGULAR = 0;
    localparam int USER_SAT      = 1;

endpackage

### rtl/affine_3x4_matrix_inverse.sv
// ----------------------------------------------------------------------------
// affine_3x4_matrix_inverse
// Pipelined inverse of a 3x4 fixed-point affine transform via the adjugate.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item is a whole 3x4 matrix, twelve signed elements of
//   ELEM_WIDTH bits with FRAC_BITS fraction bits, a00 in the lowest bits.
//   m_ channel: three items per matrix, rows 0, 1, 2 in order, tlast on row 2.
//   tuser carries the singular and saturated flags of each row.
//   A matrix is taken into a holding register and issued into the pipeline
//   one row per cycle while no m_tready stall holds it; the next matrix is
//   taken as the last row issues. The four divider lanes each finish one
//   element per cycle unless stalled. Each row computes its own cofactors
//   and the determinant (as adjugate row times matrix column), then runs
//   four restoring dividers of ELEM_WIDTH+1 stages.
//   From the matrix handshake a row passes the holding register, stages 0
//   to 6, the divider stages and the output register before m_tvalid.
//   Reset clears the valid bits of every stage; no result is pending after.
//   A stall on m_tready freezes the whole pipeline; the holding register
//   still takes one more matrix while it is empty.
// ----------------------------------------------------------------------------
module affine_3x4_matrix_inverse
    import affinv_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // a00 a01 a02 a03 a10 a11 a12 a13 a20 a21 a22 a23, zero padded
    input  logic [((12*ELEM_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // row_index col0 col1 col2 col3, zero padded
    output logic [((ROW_W+4*ELEM_WIDTH+7)/8)*8-1:0] m_tdata,
    // singular saturated
    output logic [USER_W-1:0]    m_tuser,
    output logic                 m_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    localparam int W    = ELEM_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int CW   = 2*W + 1;               // cofactor
    localparam int MW   = 2*W + 1;               // partial product
    localparam int DW   = 3*W + 2;               // determinant and translation sum
    localparam int NW   = 3*W + 2*F + 3;         // rounded numerator
    localparam int QW   = W + 1;                 // quotient bits
    localparam int RW   = (NW > DW + QW) ? NW : DW + QW;
    localparam int OTW  = ((ROW_W + 4*W + 7)/8)*8;
    localparam int OPAD = OTW - ROW_W - 4*W;

    logic en;
    logic s_acc;

    // ------------------------------------------------------------------
    // matrix holding register and row sequencer
    // ------------------------------------------------------------------
    logic signed [W-1:0] hold_reg [N_ROWS][N_COLS];
    logic                hold_valid_reg, hold_valid_next;
    logic [ROW_W-1:0]    row_cnt_reg, row_cnt_next;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = !hold_valid_reg || (en && row_cnt_reg == LAST_ROW);
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        row_cnt_next    = row_cnt_reg;
        if (hold_valid_reg && en) begin
            if (row_cnt_reg == LAST_ROW) begin
                row_cnt_next    = FIRST_ROW;
                hold_valid_next = 1'b0;
            end else begin
                row_cnt_next = row_cnt_reg + 1'b1;
            end
        end
        if (s_acc) begin
            hold_valid_next = 1'b1;
            row_cnt_next    = FIRST_ROW;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            row_cnt_reg    <= FIRST_ROW;
        end else begin
            hold_valid_reg <= hold_valid_next;
            row_cnt_reg    <= row_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            for (int i = 0; i < N_ROWS; i++) begin
                for (int j = 0; j < N_COLS; j++) begin
                    hold_reg[i][j] <= s_tdata[(i*N_COLS+j)*W +: W];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 0: pick operands of the issued row
    // ------------------------------------------------------------------
    logic signed [W-1:0] s0_p1_next [3], s0_p2_next [3], s0_q1_next [3], s0_q2_next [3];
    logic signed [W-1:0] s0_cr_next [3], s0_raw_next [N_COLS];
    logic signed [W-1:0] s0_p1_reg [3], s0_p2_reg [3], s0_q1_reg [3], s0_q2_reg [3];
    logic signed [W-1:0] s0_cr_reg [3], s0_ct_reg [3], s0_raw_reg [N_COLS];
    logic [ROW_W-1:0]    s0_row_reg;

    // adj[r][k] = E(k+1,r+1)*E(k+2,r+2) - E(k+1,r+2)*E(k+2,r+1), indices mod 3
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s0_p1_next[k] = '0;
            s0_p2_next[k] = '0;
            s0_q1_next[k] = '0;
            s0_q2_next[k] = '0;
            s0_cr_next[k] = '0;
        end
        for (int j = 0; j < N_COLS; j++) s0_raw_next[j] = '0;
        for (int rr = 0; rr < 3; rr++) begin
            if (row_cnt_reg == ROW_W'(rr)) begin
                for (int k = 0; k < 3; k++) begin
                    s0_p1_next[k] = hold_reg[(k == 2) ? 0 : k+1][(rr == 2) ? 0 : rr+1];
                    s0_p2_next[k] = hold_reg[(k == 0) ? 2 : k-1][(rr == 0) ? 2 : rr-1];
                    s0_q1_next[k] = hold_reg[(k == 2) ? 0 : k+1][(rr == 0) ? 2 : rr-1];
                    s0_q2_next[k] = hold_reg[(k == 0) ? 2 : k-1][(rr == 2) ? 0 : rr+1];
                    s0_cr_next[k] = hold_reg[k][rr];
                end
                for (int j = 0; j < N_COLS; j++) s0_raw_next[j] = hold_reg[rr][j];
            end
        end
    end

    // ------------------------------------------------------------------
    // pipeline valid bits
    // ------------------------------------------------------------------
    logic [6:0]    fe_valid_reg;   // stages 0..6
    logic [QW:0]   dv_valid_reg;   // divider stages 0..QW
    logic          out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fe_valid_reg  <= '0;
            dv_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            fe_valid_reg  <= {fe_valid_reg[5:0], hold_valid_reg};
            dv_valid_reg  <= {dv_valid_reg[QW-1:0], fe_valid_reg[6]};
            out_valid_reg <= dv_valid_reg[QW];
        end
    end

    // ------------------------------------------------------------------
    // stages 0..6: cofactors, determinant, translation, numerators
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]    s1_row_reg, s2_row_reg, s3_row_reg, s4_row_reg, s5_row_reg;
    logic [ROW_W-1:0]    s6_row_reg;
    logic signed [W-1:0] s1_raw_reg [N_COLS], s2_raw_reg [N_COLS], s3_raw_reg [N_COLS];
    logic signed [W-1:0] s4_raw_reg [N_COLS], s5_raw_reg [N_COLS], s6_raw_reg [N_COLS];
    logic signed [W-1:0] s1_cr_reg [3], s1_ct_reg [3], s2_cr_reg [3], s2_ct_reg [3];
    logic signed [2*W-1:0] s1_pp_reg [3], s1_qq_reg [3];
    logic signed [CW-1:0]  s2_cof_reg [3], s3_cof_reg [3], s4_cof_reg [3];
    logic signed [MW-1:0]  s3_dlo_reg [3], s3_dhi_reg [3], s3_tlo_reg [3], s3_thi_reg [3];
    logic signed [DW-1:0]  s4_det_reg, s4_tr_reg;
    logic signed [DW-1:0]  det_sum, tr_sum;
    logic [2*W-1:0]        s5_cmag_reg [3];
    logic [DW-2:0]         s5_tmag_reg, s5_dmag_reg;
    logic [N_COLS-1:0]     s5_neg_reg, s6_neg_reg;
    logic                  s5_sing_reg, s6_sing_reg;
    logic [NW-1:0]         s6_num_reg [N_COLS];
    logic [DW-1:0]         s6_den_reg;
    logic signed [CW-1:0]  cof_abs [3];
    logic signed [DW-1:0]  det_abs, tr_abs;
    logic                  tr_pos;

    // determinant as adjugate row times matrix column, translation as
    // adjugate row times translation column
    always_comb begin
        det_sum = '0;
        tr_sum  = '0;
        for (int k = 0; k < 3; k++) begin
            det_sum = det_sum + (DW'(s3_dhi_reg[k]) <<< W) + DW'(s3_dlo_reg[k]);
            tr_sum  = tr_sum  + (DW'(s3_thi_reg[k]) <<< W) + DW'(s3_tlo_reg[k]);
        end
    end

    // magnitudes for the unsigned dividers
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cof_abs[k] = s4_cof_reg[k][CW-1] ? -s4_cof_reg[k] : s4_cof_reg[k];
        end
        det_abs = s4_det_reg[DW-1] ? -s4_det_reg : s4_det_reg;
        tr_abs  = s4_tr_reg[DW-1]  ? -s4_tr_reg  : s4_tr_reg;
        tr_pos  = !s4_tr_reg[DW-1] && (s4_tr_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 0
            s0_row_reg <= row_cnt_reg;
            s0_p1_reg  <= s0_p1_next;
            s0_p2_reg  <= s0_p2_next;
            s0_q1_reg  <= s0_q1_next;
            s0_q2_reg  <= s0_q2_next;
            s0_cr_reg  <= s0_cr_next;
            s0_raw_reg <= s0_raw_next;
            for (int k = 0; k < 3; k++) s0_ct_reg[k] <= hold_reg[k][3];

            // stage 1: cofactor products
            s1_row_reg <= s0_row_reg;
            s1_raw_reg <= s0_raw_reg;
            s1_cr_reg  <= s0_cr_reg;
            s1_ct_reg  <= s0_ct_reg;
            for (int k = 0; k < 3; k++) begin
                s1_pp_reg[k] <= s0_p1_reg[k] * s0_p2_reg[k];
                s1_qq_reg[k] <= s0_q1_reg[k] * s0_q2_reg[k];
            end

            // stage 2: cofactors
            s2_row_reg <= s1_row_reg;
            s2_raw_reg <= s1_raw_reg;
            s2_cr_reg  <= s1_cr_reg;
            s2_ct_reg  <= s1_ct_reg;
            for (int k = 0; k < 3; k++) begin
                s2_cof_reg[k] <= CW'(s1_pp_reg[k]) - CW'(s1_qq_reg[k]);
            end

            // stage 3: cofactor halves times column and translation
            s3_row_reg <= s2_row_reg;
            s3_raw_reg <= s2_raw_reg;
            s3_cof_reg <= s2_cof_reg;
            for (int k = 0; k < 3; k++) begin
                s3_dlo_reg[k] <= $signed({1'b0, s2_cof_reg[k][W-1:0]}) * s2_cr_reg[k];
                s3_dhi_reg[k] <= $signed(s2_cof_reg[k][CW-1:W]) * s2_cr_reg[k];
                s3_tlo_reg[k] <= $signed({1'b0, s2_cof_reg[k][W-1:0]}) * s2_ct_reg[k];
                s3_thi_reg[k] <= $signed(s2_cof_reg[k][CW-1:W]) * s2_ct_reg[k];
            end

            // stage 4: sums
            s4_row_reg <= s3_row_reg;
            s4_raw_reg <= s3_raw_reg;
            s4_cof_reg <= s3_cof_reg;
            s4_det_reg <= det_sum;
            s4_tr_reg  <= tr_sum;

            // stage 5: signs and magnitudes; translation numerator is -t
            s5_row_reg  <= s4_row_reg;
            s5_raw_reg  <= s4_raw_reg;
            s5_sing_reg <= (s4_det_reg == '0);
            s5_dmag_reg <= det_abs[DW-2:0];
            s5_tmag_reg <= tr_abs[DW-2:0];
            for (int k = 0; k < 3; k++) begin
                s5_cmag_reg[k] <= cof_abs[k][2*W-1:0];
                s5_neg_reg[k]  <= s4_cof_reg[k][CW-1] ^ s4_det_reg[DW-1];
            end
            s5_neg_reg[3] <= tr_pos ^ s4_det_reg[DW-1];

            // stage 6: rounded numerator 2n+d and denominator 2d
            s6_row_reg  <= s5_row_reg;
            s6_raw_reg  <= s5_raw_reg;
            s6_sing_reg <= s5_sing_reg;
            s6_neg_reg  <= s5_neg_reg;
            s6_den_reg  <= {s5_dmag_reg, 1'b0};
            for (int k = 0; k < 3; k++) begin
                s6_num_reg[k] <= (NW'(s5_cmag_reg[k]) << (2*F + 1)) + NW'(s5_dmag_reg);
            end
            s6_num_reg[3] <= (NW'(s5_tmag_reg) << (F + 1)) + NW'(s5_dmag_reg);
        end
    end

    // ------------------------------------------------------------------
    // divider: overflow check, then one quotient bit per stage
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]    dv_row_reg  [QW+1];
    logic signed [W-1:0] dv_raw_reg  [QW+1][N_COLS];
    logic                dv_sing_reg [QW+1];
    logic [DW-1:0]       dv_den_reg  [QW+1];
    logic [RW-1:0]       dv_rem_reg  [QW+1][N_COLS];
    logic [QW-1:0]       dv_quo_reg  [QW+1][N_COLS];
    logic [N_COLS-1:0]   dv_neg_reg  [QW+1];
    logic [N_COLS-1:0]   dv_ovf_reg  [QW+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_row_reg[0]  <= s6_row_reg;
            dv_raw_reg[0]  <= s6_raw_reg;
            dv_sing_reg[0] <= s6_sing_reg;
            dv_den_reg[0]  <= s6_den_reg;
            dv_neg_reg[0]  <= s6_neg_reg;
            for (int k = 0; k < N_COLS; k++) begin
                dv_rem_reg[0][k] <= RW'(s6_num_reg[k]);
                dv_quo_reg[0][k] <= '0;
                dv_ovf_reg[0][k] <= RW'(s6_num_reg[k]) >= (RW'(s6_den_reg) << QW);
            end
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_div
        localparam int B = QW - j;
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_row_reg[j]  <= dv_row_reg[j-1];
                dv_raw_reg[j]  <= dv_raw_reg[j-1];
                dv_sing_reg[j] <= dv_sing_reg[j-1];
                dv_den_reg[j]  <= dv_den_reg[j-1];
                dv_neg_reg[j]  <= dv_neg_reg[j-1];
                dv_ovf_reg[j]  <= dv_ovf_reg[j-1];
                for (int k = 0; k < N_COLS; k++) begin
                    if (dv_rem_reg[j-1][k] >= (RW'(dv_den_reg[j-1]) << B)) begin
                        dv_rem_reg[j][k] <= dv_rem_reg[j-1][k] - (RW'(dv_den_reg[j-1]) << B);
                        dv_quo_reg[j][k] <= dv_quo_reg[j-1][k] | (QW'(1) << B);
                    end else begin
                        dv_rem_reg[j][k] <= dv_rem_reg[j-1][k];
                        dv_quo_reg[j][k] <= dv_quo_reg[j-1][k];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // saturate, apply sign, select echo for a singular matrix
    // ------------------------------------------------------------------
    logic [QW-1:0]     lim  [N_COLS];
    logic [QW-1:0]     qsat [N_COLS];
    logic [N_COLS-1:0] col_sat;
    logic [W-1:0]      col_val [N_COLS];

    always_comb begin
        for (int k = 0; k < N_COLS; k++) begin
            lim[k] = dv_neg_reg[QW][k] ? (QW'(1) << (W-1)) : ((QW'(1) << (W-1)) - 1'b1);
            col_sat[k] = dv_ovf_reg[QW][k] || (dv_quo_reg[QW][k] > lim[k]);
            qsat[k] = col_sat[k] ? lim[k] : dv_quo_reg[QW][k];
            col_val[k] = dv_neg_reg[QW][k] ? W'(-qsat[k]) : W'(qsat[k]);
            if (dv_sing_reg[QW]) col_val[k] = dv_raw_reg[QW][k];
        end
    end

    logic [ROW_W-1:0] out_row_reg;
    logic [W-1:0]     out_col_reg [N_COLS];
    logic             out_sing_reg, out_sat_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_row_reg  <= dv_row_reg[QW];
            out_col_reg  <= col_val;
            out_sing_reg <= dv_sing_reg[QW];
            out_sat_reg  <= !dv_sing_reg[QW] && (col_sat != '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = (out_row_reg == LAST_ROW);
    assign m_tdata  = {{OPAD{1'b0}}, out_col_reg[3], out_col_reg[2], out_col_reg[1],
                       out_col_reg[0], out_row_reg};
    assign m_tuser[USER_SINGULAR] = out_sing_reg;
    assign m_tuser[USER_SAT]      = out_sat_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_seq_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> (hold_valid_reg && row_cnt_reg == FIRST_ROW))
        else $error("accepted matrix did not start at row 0");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> (row_cnt_reg != 2'd3))
        else $error("row counter out of range");

    a_sing_nosat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_sing_reg && out_sat_reg))
        else $error("singular row flagged saturated");

    a_row_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && out_row_reg != LAST_ROW && dv_valid_reg[QW])
            |=> (out_row_reg == $past(out_row_reg) + 1'b1))
        else $error("result rows out of order");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the 3x4 affine transform inverse. Matrices are sent with random
// gaps; every matrix is run through a wide-integer prediction of the
// adjugate inverse and the three predicted row items are compared field by
// field with what the block returns under random output stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import affinv_pkg::*;

    localparam int EW = 32;
    localparam int FB = 16;
    localparam int IN_W  = ((12*EW+7)/8)*8;
    localparam int OUT_W = ((ROW_W+4*EW+7)/8)*8;
    localparam int LATENCY = EW + 10;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic [EW-1:0]    col0;
        logic [EW-1:0]    col1;
        logic [EW-1:0]    col2;
        logic [EW-1:0]    col3;
        logic             singular;
        logic             saturated;
        logic             last_row;
    } row_item_t;

    logic               aclk;
    logic               aresetn;
    logic [IN_W-1:0]    s_tdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic [USER_W-1:0]  m_tuser;
    logic               m_tlast;
    logic               m_tvalid;
    logic               m_tready;

    logic [IN_W-1:0] pending_mats[$];
    row_item_t       expected_rows[$];
    int              errors;
    longint          cycles;
    bit              hold_sender;
    bit              s_taken;
    int              send_gap;
    int              stall_left;

    affine_3x4_matrix_inverse #(.FRAC_BITS(FB), .ELEM_WIDTH(EW)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // round(num/den), ties away from zero, clamped to the element range
    function automatic logic [EW-1:0] round_div(wide_t num, wide_t den, ref logic sat);
        bit    neg;
        wide_t n;
        wide_t d;
        wide_t q;
        wide_t lim;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (2*n + d) / (2*d);
        lim = neg ? (wide_t'(1) <<< (EW-1)) : ((wide_t'(1) <<< (EW-1)) - 1);
        if (q > lim) begin
            q = lim;
            sat = 1'b1;
        end
        if (neg) q = -q;
        return q[EW-1:0];
    endfunction

    // adjugate inverse of one matrix, three row items
    task automatic predict_inverse(logic [IN_W-1:0] mat);
        wide_t     e[12];
        wide_t     cf[9];
        wide_t     det;
        wide_t     tr;
        row_item_t it;
        logic      sat;
        for (int k = 0; k < 12; k++) e[k] = wide_t'($signed(mat[k*EW +: EW]));
        cf[0] = e[5]*e[10] - e[6]*e[9];
        cf[1] = e[2]*e[9]  - e[1]*e[10];
        cf[2] = e[1]*e[6]  - e[2]*e[5];
        cf[3] = e[6]*e[8]  - e[4]*e[10];
        cf[4] = e[0]*e[10] - e[2]*e[8];
        cf[5] = e[2]*e[4]  - e[0]*e[6];
        cf[6] = e[4]*e[9]  - e[5]*e[8];
        cf[7] = e[1]*e[8]  - e[0]*e[9];
        cf[8] = e[0]*e[5]  - e[1]*e[4];
        det = e[0]*cf[0] + e[1]*cf[3] + e[2]*cf[6];
        for (int r = 0; r < N_ROWS; r++) begin
            sat = 1'b0;
            it.row_index = r[ROW_W-1:0];
            it.last_row = (r == N_ROWS-1);
            if (det == 0) begin
                it.col0 = mat[(r*4+0)*EW +: EW];
                it.col1 = mat[(r*4+1)*EW +: EW];
                it.col2 = mat[(r*4+2)*EW +: EW];
                it.col3 = mat[(r*4+3)*EW +: EW];
                it.singular = 1'b1;
            end else begin
                tr = cf[r*3]*e[3] + cf[r*3+1]*e[7] + cf[r*3+2]*e[11];
                it.col0 = round_div(cf[r*3]   <<< (2*FB), det, sat);
                it.col1 = round_div(cf[r*3+1] <<< (2*FB), det, sat);
                it.col2 = round_div(cf[r*3+2] <<< (2*FB), det, sat);
                it.col3 = round_div((-tr) <<< FB, det, sat);
                it.singular = 1'b0;
            end
            it.saturated = sat;
            expected_rows.push_back(it);
        end
    endtask

    function automatic logic [IN_W-1:0] pack_mat(logic [EW-1:0] v[12]);
        logic [IN_W-1:0] m;
        m = '0;
        for (int k = 0; k < 12; k++) m[k*EW +: EW] = v[k];
        return m;
    endfunction

    // random element: extremes, small Q16.16 values or any pattern
    function automatic logic [EW-1:0] rand_elem();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return 32'h8000_0000;
        if (r < 10) return 32'h7FFF_FFFF;
        if (r < 20) return '0;
        if (r < 70) return $signed($urandom_range(0, 8 << FB)) - (4 << FB);
        return $urandom;
    endfunction

    // stimulus
    initial begin
        logic [EW-1:0] v[12];
        for (int k = 0; k < 12; k++) v[k] = '0;
        // identity with translation
        v[0] = 1 << FB; v[5] = 1 << FB; v[10] = 1 << FB;
        v[3] = 3 << FB; v[7] = -(5 << FB); v[11] = 32'h0000_8000;
        pending_mats.push_back(pack_mat(v));
        // scaled, tiny scale forces saturation
        v[0] = 2 << FB; v[5] = 32'h0000_8000; v[10] = -(4 << FB);
        pending_mats.push_back(pack_mat(v));
        v[0] = 1; v[5] = 1; v[10] = 1;
        pending_mats.push_back(pack_mat(v));
        // all zeros and all ones patterns
        pending_mats.push_back('0);
        pending_mats.push_back({IN_W{1'b1}});
        // extremes on the diagonal
        for (int k = 0; k < 12; k++) v[k] = '0;
        v[0] = 32'h8000_0000; v[5] = 32'h7FFF_FFFF; v[10] = 32'h8000_0000;
        v[3] = 32'h7FFF_FFFF; v[7] = 32'h8000_0000; v[11] = 32'h7FFF_FFFF;
        pending_mats.push_back(pack_mat(v));
        // singular: repeated row, with random rest
        for (int k = 0; k < 12; k++) v[k] = rand_elem();
        v[4] = v[0]; v[5] = v[1]; v[6] = v[2];
        pending_mats.push_back(pack_mat(v));
        // small determinant of magnitude 2, cofactor odd
        for (int k = 0; k < 12; k++) v[k] = '0;
        v[0] = 2; v[5] = 1; v[10] = 1; v[3] = 1;
        pending_mats.push_back(pack_mat(v));
        v[0] = -2; v[3] = 3;
        pending_mats.push_back(pack_mat(v));
        for (int n = 0; n < 8; n++) begin
            for (int k = 0; k < 12; k++) v[k] = $urandom;
            pending_mats.push_back(pack_mat(v));
        end
        // random part
        for (int n = 0; n < 150; n++) begin
            for (int k = 0; k < 12; k++) v[k] = rand_elem();
            if ($urandom_range(0, 9) == 0) begin
                v[8] = v[0]; v[9] = v[1]; v[10] = v[2];
            end
            pending_mats.push_back(pack_mat(v));
        end
    end

    // reset, end of run
    initial begin
        aresetn = 1'b0;
        hold_sender = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        // drain fully once mid-run
        wait (pending_mats.size() < 100);
        hold_sender = 1'b1;
        wait (expected_rows.size() == 0 && s_tvalid == 1'b0);
        @(negedge aclk);
        hold_sender = 1'b0;
        wait (pending_mats.size() == 0 && s_tvalid == 1'b0);
        wait (expected_rows.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0 && expected_rows.size() == 0) begin
            $display("PASS affine_3x4_matrix_inverse");
        end else begin
            $display("FAIL affine_3x4_matrix_inverse");
        end
        $finish;
    end

    // driver, advances only on a handshake seen at the rising edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end else if (!s_tvalid || s_taken) begin
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_mats.size() > 0 && !hold_sender) begin
                s_tdata  <= pending_mats.pop_front();
                s_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready   <= 1'b1;
            stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    // monitor
    always @(posedge aclk) begin
        row_item_t want;
        row_item_t got;
        if (!aresetn) begin
            errors  <= 0;
            cycles  <= 0;
            s_taken <= 1'b0;
        end else begin
            cycles  <= cycles + 1;
            s_taken <= s_tvalid && s_tready;
            if (cycles > CYCLE_LIMIT) begin
                $display("%0t timeout", $time);
                $display("FAIL affine_3x4_matrix_inverse");
                $finish;
            end
            if (s_tvalid && s_tready) predict_inverse(s_tdata);
            if (m_tvalid && m_tready) begin
                got.row_index = m_tdata[ROW_W-1:0];
                got.col0 = m_tdata[ROW_W +: EW];
                got.col1 = m_tdata[ROW_W+EW +: EW];
                got.col2 = m_tdata[ROW_W+2*EW +: EW];
                got.col3 = m_tdata[ROW_W+3*EW +: EW];
                got.singular  = m_tuser[USER_SINGULAR];
                got.saturated = m_tuser[USER_SAT];
                got.last_row  = m_tlast;
                if (expected_rows.size() == 0) begin
                    $display("%0t unexpected row item: expected none, actual %h",
                             $time, got);
                    errors <= errors + 1;
                end else begin
                    want = expected_rows.pop_front();
                    if (got !== want) begin
                        $display("%0t row mismatch: expected %h actual %h",
                                 $time, want, got);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

### sim.f
rtl/affinv_pkg.sv
rtl/affine_3x4_matrix_inverse.sv
bench/tb_top.sv
